// ===== rtl/rsm_pkg.sv =====
// Shared types and codes of the record slot mapper.
// Used by rsm_ctrl, rsm_dpath and record_slot_mapper_core; depends on nothing.
package rsm_pkg;

  // One input item of the command channel.
  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  record_number;
    logic [4:0]  bitmap_index;
    logic [63:0] bitmap_word;
  } rsm_in_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  status;
    logic [11:0] sector;
    logic [9:0]  slot_in_sector;
    logic [5:0]  record_out;
  } rsm_out_t;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_RECS_PER_SECTOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MODE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_OPEN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_LOCK     = 3'd4;

  // Item operations.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_ADD    = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  // File open modes.
  localparam logic [1:0] OM_READ       = 2'd0;
  localparam logic [1:0] OM_WRITE      = 2'd1;
  localparam logic [1:0] OM_READ_WRITE = 2'd2;
  localparam logic [1:0] OM_EXTEND     = 2'd3;

  // Result status codes.
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_NOT_OPEN = 4'd1;
  localparam logic [3:0] ST_LOCKED   = 4'd2;
  localparam logic [3:0] ST_MODE     = 4'd3;
  localparam logic [3:0] ST_NO_REC   = 4'd4;
  localparam logic [3:0] ST_DELETED  = 4'd5;
  localparam logic [3:0] ST_FULL     = 4'd6;
  localparam logic [3:0] ST_EXTEND   = 4'd7;
  localparam logic [3:0] ST_BEYOND   = 4'd8;

  // Slot table entry codes. The spare code is never written and counts as live.
  localparam logic [1:0] SLOT_FREE    = 2'd0;
  localparam logic [1:0] SLOT_LIVE    = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;
  localparam logic [1:0] SLOT_SPARE   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic check;
    logic rd_scan;
    logic scan_adv;
    logic scan_found;
    logic scan_full;
    logic div_init;
    logic div_step;
    logic word_adv;
    logic bit_load;
    logic bit_step;
    logic loc_ok;
    logic loc_fail;
  } rsm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_locate;
    logic go_scan;
    logic scan_end;
    logic scan_free;
    logic div_last;
    logic word_hit;
    logic word_last;
    logic bit_hit;
  } rsm_sts_t;

endpackage

// ===== rtl/rsm_ctrl.sv =====
// Sequencing state machine of the record slot mapper.
// Depends on rsm_pkg for the command and status structs.
module rsm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  input  rsm_pkg::rsm_sts_t sts,
  output rsm_pkg::rsm_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD    = 10'b0000000010,
    S_CHECK = 10'b0000000100,
    S_SRD   = 10'b0000001000,
    S_SCHK  = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_WRD   = 10'b0001000000,
    S_WCHK  = 10'b0010000000,
    S_BIT   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.go_locate) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else if (sts.go_scan) begin
          state_nxt = S_SRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SRD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = S_SCHK;
      end
      S_SCHK: begin
        if (sts.scan_end) begin
          cmd.scan_full = 1'b1;
          state_nxt     = S_DONE;
        end else if (sts.scan_free) begin
          cmd.scan_found = 1'b1;
          cmd.div_init   = 1'b1;
          state_nxt      = S_DIV;
        end else begin
          cmd.scan_adv = 1'b1;
          state_nxt    = S_SRD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        if (sts.word_hit) begin
          cmd.bit_load = 1'b1;
          state_nxt    = S_BIT;
        end else if (sts.word_last) begin
          cmd.loc_fail = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.word_adv = 1'b1;
          state_nxt    = S_WRD;
        end
      end
      S_BIT: begin
        if (sts.bit_hit) begin
          cmd.loc_ok = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.bit_step = 1'b1;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// ===== rtl/rsm_dpath.sv =====
// Datapath of the record slot mapper: configuration registers, slot table,
// cluster bitmap store, divider, bitmap scan and result registers. Uses rsm_pkg.
module rsm_dpath #(
  parameter int MAP_BITS  = 1600,
  parameter int MAX_SLOTS = 36
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rsm_pkg::rsm_in_t                in_data,
  input  logic                            cfg_we,
  input  logic [rsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  rsm_pkg::rsm_cmd_t               cmd,
  output rsm_pkg::rsm_sts_t               sts,
  output rsm_pkg::rsm_out_t               out_data
);

  localparam int MAP_WORDS = (MAP_BITS + 63) / 64;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SIDX_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LAST_BITS = MAP_BITS - (MAP_WORDS - 1) * 64;
  localparam logic [63:0] LAST_MASK = {64{1'b1}} >> (64 - LAST_BITS);
  localparam int DIV_STEPS = 6;

  // Count of set bits in one bitmap word.
  function automatic logic [6:0] popcnt64(input logic [63:0] w);
    logic [6:0] n;
    n = '0;
    for (int k = 0; k < 64; k++) begin
      n = n + 7'(w[k]);
    end
    return n;
  endfunction

  // Configuration registers.
  logic [9:0] rps_r;
  logic [5:0] cap_r;
  logic [1:0] omode_r;
  logic       fopen_r;
  logic       lock_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rps_r   <= 10'd1;
      cap_r   <= '0;
      omode_r <= rsm_pkg::OM_READ;
      fopen_r <= 1'b0;
      lock_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsm_pkg::CFG_RECS_PER_SECTOR: rps_r   <= cfg_wdata;
        rsm_pkg::CFG_CAPACITY:        cap_r   <= cfg_wdata[5:0];
        rsm_pkg::CFG_OPEN_MODE:       omode_r <= cfg_wdata[1:0];
        rsm_pkg::CFG_FILE_OPEN:       fopen_r <= cfg_wdata[0];
        rsm_pkg::CFG_UPDATE_LOCK:     lock_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Item register, taken at the transfer.
  rsm_pkg::rsm_in_t in_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
  end

  // Scan and search registers.
  logic [6:0]        scan_idx_r;
  logic [WIDX_W-1:0] w_r;
  logic [5:0]        cnt_r;

  // Slot table: memory with a valid bit per entry; an invalid entry reads as free.
  logic [1:0]           slot_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] slot_vld_r;
  logic [1:0]           slot_rd_r;
  logic                 slot_rd_vld_r;
  logic [SIDX_W-1:0]    slot_rd_addr;
  logic [SIDX_W-1:0]    slot_wr_addr;
  logic [1:0]           slot_wr_data;
  logic                 slot_we;
  logic [1:0]           slot_st;
  logic                 del_ok;

  assign slot_rd_addr = cmd.rd_scan ? SIDX_W'(scan_idx_r) : SIDX_W'(in_r.record_number);
  assign slot_we      = (cmd.check && del_ok) || cmd.scan_found;
  assign slot_wr_addr = cmd.scan_found ? SIDX_W'(scan_idx_r) : SIDX_W'(in_r.record_number);
  assign slot_wr_data = cmd.scan_found ? rsm_pkg::SLOT_LIVE : rsm_pkg::SLOT_DELETED;

  always_ff @(posedge clk) begin
    slot_rd_r     <= slot_mem[slot_rd_addr];
    slot_rd_vld_r <= slot_vld_r[slot_rd_addr];
    if (slot_we) begin
      slot_mem[slot_wr_addr] <= slot_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
    end else if (slot_we) begin
      slot_vld_r[slot_wr_addr] <= 1'b1;
    end
  end

  assign slot_st = slot_rd_vld_r ? slot_rd_r : rsm_pkg::SLOT_FREE;

  // Cluster bitmap store, one word per entry, invalid words read as zero.
  logic [63:0]          map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] map_vld_r;
  logic [63:0]          map_rd_r;
  logic                 map_rd_vld_r;
  logic                 map_we;
  logic [WIDX_W-1:0]    map_wr_addr;

  assign map_we      = cmd.check && (in_r.mode == rsm_pkg::OP_LOAD) &&
                       (int'(in_r.bitmap_index) < MAP_WORDS);
  assign map_wr_addr = WIDX_W'(in_r.bitmap_index);

  always_ff @(posedge clk) begin
    map_rd_r     <= map_mem[w_r];
    map_rd_vld_r <= map_vld_r[w_r];
    if (map_we) begin
      map_mem[map_wr_addr] <= in_r.bitmap_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r <= '0;
    end else if (map_we) begin
      map_vld_r[map_wr_addr] <= 1'b1;
    end
  end

  // Live slot count.
  logic [5:0] live_r;

  // Admission checks, in the order the operations demand.
  logic [3:0] chk_status;
  logic       go_locate;
  logic       go_scan;
  logic       rec_in;
  logic       slot_live;

  assign rec_in    = int'(in_r.record_number) < MAX_SLOTS;
  assign slot_live = (slot_st == rsm_pkg::SLOT_LIVE) || (slot_st == rsm_pkg::SLOT_SPARE);

  always_comb begin
    chk_status = rsm_pkg::ST_OK;
    go_locate  = 1'b0;
    go_scan    = 1'b0;
    del_ok     = 1'b0;
    unique case (in_r.mode)
      rsm_pkg::OP_LOAD: begin
        chk_status = rsm_pkg::ST_OK;
      end
      rsm_pkg::OP_READ: begin
        priority if (!fopen_r) begin
          chk_status = rsm_pkg::ST_NOT_OPEN;
        end else if (!rec_in || !slot_live) begin
          chk_status = rsm_pkg::ST_NO_REC;
        end else if (lock_r) begin
          chk_status = rsm_pkg::ST_LOCKED;
        end else if ((omode_r == rsm_pkg::OM_WRITE) || (omode_r == rsm_pkg::OM_EXTEND)) begin
          chk_status = rsm_pkg::ST_MODE;
        end else begin
          go_locate = 1'b1;
        end
      end
      rsm_pkg::OP_ADD: begin
        priority if (!fopen_r) begin
          chk_status = rsm_pkg::ST_NOT_OPEN;
        end else if ((omode_r == rsm_pkg::OM_READ) || (omode_r == rsm_pkg::OM_EXTEND)) begin
          chk_status = rsm_pkg::ST_MODE;
        end else if (int'(live_r) == MAX_SLOTS) begin
          chk_status = rsm_pkg::ST_FULL;
        end else if (live_r == cap_r) begin
          chk_status = rsm_pkg::ST_EXTEND;
        end else begin
          go_scan = 1'b1;
        end
      end
      rsm_pkg::OP_DELETE: begin
        priority if (lock_r) begin
          chk_status = rsm_pkg::ST_LOCKED;
        end else if ((omode_r != rsm_pkg::OM_WRITE) &&
                     (omode_r != rsm_pkg::OM_READ_WRITE)) begin
          chk_status = rsm_pkg::ST_MODE;
        end else if (!rec_in || (slot_st == rsm_pkg::SLOT_FREE)) begin
          chk_status = rsm_pkg::ST_NO_REC;
        end else if (slot_st == rsm_pkg::SLOT_DELETED) begin
          chk_status = rsm_pkg::ST_DELETED;
        end else begin
          del_ok = 1'b1;
        end
      end
      default: begin
        chk_status = rsm_pkg::ST_OK;
      end
    endcase
  end

  // Restoring divider: one quotient bit per step gives rec / rps and rec % rps.
  logic [5:0]  dq_r;
  logic [9:0]  rem_r;
  logic [2:0]  div_cnt_r;
  logic [9:0]  rps_eff;
  logic [5:0]  dividend;
  logic [10:0] rem_sh;
  logic [10:0] rem_dif;
  logic        div_ge;

  assign rps_eff  = (rps_r == '0) ? 10'd1 : rps_r;
  assign dividend = (in_r.mode == rsm_pkg::OP_ADD) ? 6'(scan_idx_r) : in_r.record_number;
  assign rem_sh   = {rem_r, dq_r[5]};
  assign rem_dif  = rem_sh - {1'b0, rps_eff};
  assign div_ge   = rem_sh >= {1'b0, rps_eff};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dq_r      <= dividend;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      dq_r      <= {dq_r[4:0], div_ge};
      rem_r     <= div_ge ? rem_dif[9:0] : rem_sh[9:0];
      div_cnt_r <= div_cnt_r + 3'd1;
    end
  end

  // Bitmap scan: whole words first, then bit by bit inside the word that holds the target.
  logic [6:0]  sec_num;
  logic [5:0]  target;
  logic        sec_odd;
  logic        w_last;
  logic [63:0] word_m;
  logic [6:0]  word_pop;
  logic [7:0]  cnt_sum;
  logic        word_hit;
  logic [63:0] sh_r;
  logic [5:0]  bit_rem_r;
  logic [5:0]  bitpos_r;
  logic        bit_hit;

  assign sec_num  = 7'(dq_r) + 7'd1;
  assign target   = sec_num[6:1];
  assign sec_odd  = sec_num[0];
  assign w_last   = (int'(w_r) == MAP_WORDS - 1);
  assign word_m   = (map_rd_vld_r ? map_rd_r : 64'd0) & (w_last ? LAST_MASK : {64{1'b1}});
  assign word_pop = popcnt64(word_m);
  assign cnt_sum  = 8'(cnt_r) + 8'(word_pop);
  assign word_hit = cnt_sum > 8'(target);
  assign bit_hit  = sh_r[0] && (bit_rem_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      scan_idx_r <= '0;
      w_r        <= '0;
      cnt_r      <= '0;
    end else begin
      if (cmd.scan_adv) begin
        scan_idx_r <= scan_idx_r + 7'd1;
      end
      if (cmd.word_adv) begin
        cnt_r <= cnt_sum[5:0];
        w_r   <= w_r + WIDX_W'(1);
      end
    end
    if (cmd.bit_load) begin
      sh_r      <= word_m;
      bit_rem_r <= target - cnt_r;
      bitpos_r  <= '0;
    end else if (cmd.bit_step) begin
      if (sh_r[0]) begin
        bit_rem_r <= bit_rem_r - 6'd1;
      end
      sh_r     <= {1'b0, sh_r[63:1]};
      bitpos_r <= bitpos_r + 6'd1;
    end
  end

  // Live count follows deletions and successful adds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (cmd.check && del_ok) begin
      if (live_r != '0) begin
        live_r <= live_r - 6'd1;
      end
    end else if (cmd.loc_ok && (in_r.mode == rsm_pkg::OP_ADD)) begin
      live_r <= live_r + 6'd1;
    end
  end

  // Result registers.
  logic [3:0]  status_r;
  logic [11:0] sector_r;
  logic [9:0]  slot_r;
  logic [5:0]  recout_r;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      status_r <= chk_status;
      sector_r <= '0;
      slot_r   <= '0;
      recout_r <= in_r.record_number;
    end else begin
      if (cmd.scan_full) begin
        status_r <= rsm_pkg::ST_FULL;
      end
      if (cmd.scan_found) begin
        recout_r <= 6'(scan_idx_r);
      end
      if (cmd.loc_fail) begin
        status_r <= rsm_pkg::ST_BEYOND;
      end
      if (cmd.loc_ok) begin
        status_r <= rsm_pkg::ST_OK;
        sector_r <= 12'({w_r, bitpos_r, sec_odd});
        slot_r   <= rem_r;
      end
    end
  end

  assign out_data.status         = status_r;
  assign out_data.sector         = sector_r;
  assign out_data.slot_in_sector = slot_r;
  assign out_data.record_out     = recout_r;

  // Status to the controller.
  assign sts.go_locate = go_locate;
  assign sts.go_scan   = go_scan;
  assign sts.scan_end  = !((int'(scan_idx_r) < MAX_SLOTS) && (scan_idx_r < 7'(cap_r)));
  assign sts.scan_free = (slot_st == rsm_pkg::SLOT_FREE);
  assign sts.div_last  = (div_cnt_r == 3'(DIV_STEPS - 1));
  assign sts.word_hit  = word_hit;
  assign sts.word_last = w_last;
  assign sts.bit_hit   = bit_hit;

endmodule

// ===== rtl/record_slot_mapper_core.sv =====
// Record slot mapper top level: one item at a time. A bitmap load or a rejected item gives
// its result strobe once checked; a read also divides, reads and counts the bitmap words in
// turn up to the word holding the cluster, then walks that word bit by bit; an add first
// searches the slot table, reading and checking one slot after another. start is taken
// again in the cycle after the strobe; results cannot be held off. Synchronous reset clears
// configuration, slot table, bitmap, live count.
module record_slot_mapper_core #(
  parameter int MAP_BITS  = 1600,
  parameter int MAX_SLOTS = 36
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  rsm_pkg::rsm_in_t                in_data,
  output logic                            out_valid,
  output rsm_pkg::rsm_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [rsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  rsm_pkg::rsm_cmd_t cmd;
  rsm_pkg::rsm_sts_t sts;

  // Sequencer.
  rsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  rsm_dpath #(
    .MAP_BITS  (MAP_BITS),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // A transfer always starts work.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer did not start work");

  // A result strobe lasts one cycle and only ends an item in flight.
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy ##1 !out_valid)
    else $error("result strobe held or outside an item");

  // A failed item carries no location.
  a_fail_no_loc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != rsm_pkg::ST_OK)) |->
      ((out_data.sector == '0) && (out_data.slot_in_sector == '0)))
    else $error("location given with a failure status");
`endif

endmodule
